// ===== src/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
// Used by utf8d_decode and utf8_byte_stream_decoder; depends on nothing.
package utf8d_pkg;

  localparam int CpWidth = 21;

  localparam logic [CpWidth-1:0] CpReplacement = 21'h00FFFD;

  localparam logic [1:0] NeedNone  = 2'd0;
  localparam logic [1:0] NeedOne   = 2'd1;
  localparam logic [1:0] NeedTwo   = 2'd2;
  localparam logic [1:0] NeedThree = 2'd3;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]         need;
    logic [1:0]         taken;
    logic [CpWidth-1:0] partial;
  } dec_state_t;

  // Results caused by one byte: rep_n replacement characters, then an
  // optional decoded code point.
  typedef struct packed {
    logic [2:0]         rep_n;
    logic               has_tail;
    logic [CpWidth-1:0] tail_cp;
  } run_t;

endpackage

// ===== src/utf8d_decode.sv =====
// Combinational decode of one byte against the current decoder state.
// Produces the next state and the run of results the byte causes; uses utf8d_pkg.
module utf8d_decode (
  input  utf8d_pkg::dec_state_t state,
  input  logic [7:0]            byte_value,
  input  logic                  end_of_text,
  output utf8d_pkg::dec_state_t state_next,
  output utf8d_pkg::run_t       run
);
  import utf8d_pkg::*;

  logic                 is_cont;
  logic                 fresh;
  logic [1:0]           taken_inc;
  logic [1:0]           need_dec;
  logic [CpWidth-1:0]   shifted;
  logic [1:0]           lead_need;
  logic [CpWidth-1:0]   lead_bits;

  assign is_cont   = (byte_value[7:6] == 2'b10);
  assign taken_inc = state.taken + 2'd1;
  assign need_dec  = state.need - 2'd1;
  assign shifted   = {state.partial[CpWidth-7:0], byte_value[5:0]};

  always_comb begin
    lead_need = NeedNone;
    lead_bits = '0;
    unique casez (byte_value)
      8'b110?_????: begin
        lead_need = NeedOne;
        lead_bits = {16'd0, byte_value[4:0]};
      end
      8'b1110_????: begin
        lead_need = NeedTwo;
        lead_bits = {17'd0, byte_value[3:0]};
      end
      8'b1111_0???: begin
        lead_need = NeedThree;
        lead_bits = {18'd0, byte_value[2:0]};
      end
      default: begin
        lead_need = NeedNone;
        lead_bits = '0;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    run.rep_n    = 3'd0;
    run.has_tail = 1'b0;
    run.tail_cp  = '0;
    fresh        = 1'b1;

    if (state.need != NeedNone) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (need_dec == NeedNone) begin
          run.has_tail = 1'b1;
          run.tail_cp  = shifted;
          state_next   = '0;
        end else if (end_of_text) begin
          run.rep_n  = {1'b0, taken_inc} + 3'd1;
          state_next = '0;
        end else begin
          state_next.need    = need_dec;
          state_next.taken   = taken_inc;
          state_next.partial = shifted;
        end
      end else begin
        run.rep_n  = {1'b0, state.taken} + 3'd1;
        state_next = '0;
      end
    end

    if (fresh) begin
      if (!byte_value[7]) begin
        run.has_tail = 1'b1;
        run.tail_cp  = {13'd0, byte_value};
      end else if (lead_need == NeedNone) begin
        run.rep_n = run.rep_n + 3'd1;
      end else if (end_of_text) begin
        run.rep_n  = run.rep_n + 3'd1;
        state_next = '0;
      end else begin
        state_next.need    = lead_need;
        state_next.taken   = 2'd0;
        state_next.partial = lead_bits;
      end
    end
  end

endmodule

// ===== src/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder top level: input handshake, decoder state and result register.
// Uses utf8d_pkg and utf8d_decode.
//
// A byte is taken in every cycle while each byte yields at most one code point and
// out_ready is high: the byte is decoded in the cycle it is accepted and its result
// shows on the output register in the next cycle. A byte that causes k results
// (malformed input, up to four replacement characters) holds the single result
// register until all k have left, so the next byte waits until the last one leaves;
// bytes in the middle of a sequence cause no result. Back-pressure from out_ready
// stalls the input only when the last result of the current byte cannot leave.
module utf8_byte_stream_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    byte_value,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utf8d_pkg::CpWidth-1:0] code_point,
  output logic                          is_replacement,
  output logic                          last_of_run
);
  import utf8d_pkg::*;

  dec_state_t state;
  dec_state_t state_next;
  run_t       run;
  run_t       run_next;
  logic       in_xfer;
  logic       out_xfer;

  utf8d_decode u_decode (
    .state       (state),
    .byte_value  (byte_value),
    .end_of_text (end_of_text),
    .state_next  (state_next),
    .run         (run_next)
  );

  assign out_valid      = (run.rep_n != 3'd0) || run.has_tail;
  assign last_of_run    = (run.rep_n == 3'd0) || ((run.rep_n == 3'd1) && !run.has_tail);
  assign is_replacement = (run.rep_n != 3'd0);
  assign code_point     = (run.rep_n != 3'd0) ? CpReplacement : run.tail_cp;

  assign out_xfer = out_valid && out_ready;
  assign in_ready = !out_valid || (out_ready && last_of_run);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      run.rep_n    <= 3'd0;
      run.has_tail <= 1'b0;
    end else if (in_xfer) begin
      state <= state_next;
      run   <= run_next;
    end else if (out_xfer) begin
      if (run.rep_n != 3'd0) begin
        run.rep_n <= run.rep_n - 3'd1;
      end else begin
        run.has_tail <= 1'b0;
      end
    end
  end

endmodule

// ===== src/utf8d_check.sv =====
// Port-level checks for the UTF-8 byte stream decoder, bound to its top level.
// Sees only the top-level ports; depends on utf8d_pkg.
module utf8d_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    byte_value,
  input logic                          end_of_text,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [utf8d_pkg::CpWidth-1:0] code_point,
  input logic                          is_replacement,
  input logic                          last_of_run
);
  import utf8d_pkg::*;

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
      && $stable(is_replacement) && $stable(last_of_run))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_replacement |-> code_point == CpReplacement)
    else $error("replacement flag without U+FFFD");

  // An ASCII byte or the final byte of a text always yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!byte_value[7] || end_of_text) |=> out_valid)
    else $error("ASCII or final byte gave no result");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind utf8_byte_stream_decoder utf8d_check u_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .byte_value     (byte_value),
  .end_of_text    (end_of_text),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .code_point     (code_point),
  .is_replacement (is_replacement),
  .last_of_run    (last_of_run)
);
